/* src/tet_pressure_gradient_correction_unit_defines.svh */
// Assertion macros used by the checker file of the pressure gradient unit.
// Depends on nothing; each macro takes the clock and the active-low reset.
`ifndef TET_PRESSURE_GRADIENT_CORRECTION_UNIT_DEFINES_SVH
`define TET_PRESSURE_GRADIENT_CORRECTION_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPGC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tpgc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tpgc assertion failed");

`endif

/* src/tpgc_pkg.sv */
// Types and constants of the tetrahedron pressure gradient correction unit.
// Used by the lane, volume, top level and checker files; depends on nothing.
package tpgc_pkg;

    localparam int NODES_PER_ELEMENT = 4;
    localparam int NODE_W            = 16;
    localparam int DATA_W            = 32;
    localparam int SUM_W             = 64;
    localparam int VF_W              = 16;
    localparam int V4_W              = 31;
    localparam int FRAC_W            = 16;

    localparam logic [VF_W-1:0] VOLUME_FACTOR_RESET = 16'd2731;
    localparam logic [1:0]      LAST_NODE           = 2'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_VOL = 1'b1;

    // One node of a tetrahedron as it arrives.
    typedef struct packed {
        logic [NODE_W-1:0]        node_index;
        logic signed [DATA_W-1:0] pressure;
        logic signed [DATA_W-1:0] grad_x;
        logic signed [DATA_W-1:0] grad_y;
        logic signed [DATA_W-1:0] grad_z;
        logic signed [DATA_W-1:0] det_jacobian;
        logic                     solid_material;
    } in_item_t;

    // One nodal correction, or the error item of a bad element.
    typedef struct packed {
        logic [NODE_W-1:0]        out_node;
        logic signed [DATA_W-1:0] contrib_x;
        logic signed [DATA_W-1:0] contrib_y;
        logic signed [DATA_W-1:0] contrib_z;
        logic                     status;
        logic                     last;
    } out_item_t;

    // Enables that the sequencer hands to every dimension lane.
    typedef struct packed {
        logic clear;
        logic prod_en;
        logic acc_en;
        logic mag_en;
        logic cmul_en;
        logic csum_en;
    } lane_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_VOL,
        ST_CHK,
        ST_CSUM,
        ST_OUT,
        ST_ERR
    } state_t;

endpackage

/* src/tet_pressure_gradient_correction_unit.sv */
// A linear tetrahedron arrives as four node items. Each node is accepted, then
// accumulated in the three dimension lanes. After the fourth node a solid
// element is dropped at once; a fluid element forms the quarter volume and the
// corrections, then gives four result items, one per node in arrival order, each
// held until taken. An element whose quarter volume is zero, as for a non-positive
// determinant, gives one error item instead.
// The block takes the next node only after the element's results are all taken,
// so one sequencer paces the whole element. The volume factor register can be
// written at any time the block is idle; its write port is always ready.
module tet_pressure_gradient_correction_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpgc_pkg::VF_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tpgc_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tpgc_pkg::out_item_t           m_data
);
    import tpgc_pkg::*;

    state_t                      state_reg;
    state_t                      state_next;
    logic [1:0]                  cnt_reg;
    logic [1:0]                  cnt_next;
    logic [1:0]                  out_idx_reg;
    logic [1:0]                  out_idx_next;
    logic [VF_W-1:0]             vf_reg;
    logic [NODE_W-1:0]           nodes_reg [NODES_PER_ELEMENT];
    logic signed [DATA_W-1:0]    detj_reg;
    logic                        solid_reg;
    logic                        accept;
    lane_ctrl_t                  ctrl;
    logic [V4_W-1:0]             v4;
    logic signed [DATA_W-1:0]    cx;
    logic signed [DATA_W-1:0]    cy;
    logic signed [DATA_W-1:0]    cz;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Volume factor register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= VOLUME_FACTOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            vf_reg <= cfg_data;
        end
    end

    // Node numbers and the fourth node's element data are kept on accept.
    always_ff @(posedge aclk) begin
        if (accept) begin
            nodes_reg[cnt_reg] <= s_data.node_index;
            detj_reg           <= s_data.det_jacobian;
            solid_reg          <= s_data.solid_material;
        end
    end

    // Next state of the element sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_ACC;
            end
            ST_ACC: begin
                if (cnt_reg != LAST_NODE || solid_reg) state_next = ST_IDLE;
                else                                   state_next = ST_VOL;
            end
            ST_VOL:  state_next = ST_CHK;
            ST_CHK: begin
                state_next = (v4 == '0) ? ST_ERR : ST_CSUM;
            end
            ST_CSUM: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready && out_idx_reg == LAST_NODE) state_next = ST_IDLE;
            end
            ST_ERR: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshakes, lane enables and counters.
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        m_valid      = (state_reg == ST_OUT) || (state_reg == ST_ERR);
        ctrl         = '0;
        cnt_next     = cnt_reg;
        out_idx_next = out_idx_reg;
        ctrl.prod_en = s_valid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: ;
            ST_ACC: begin
                ctrl.acc_en = 1'b1;
                cnt_next    = cnt_reg + 2'd1;
                ctrl.clear  = (cnt_reg == LAST_NODE) && solid_reg;
            end
            ST_VOL:  ctrl.mag_en = 1'b1;
            ST_CHK:  ctrl.cmul_en = 1'b1;
            ST_CSUM: begin
                ctrl.csum_en = 1'b1;
                out_idx_next = '0;
            end
            ST_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 2'd1;
                    ctrl.clear   = (out_idx_reg == LAST_NODE);
                end
            end
            ST_ERR: ctrl.clear = m_ready;
            default: ;
        endcase
        if (ctrl.clear) begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            out_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_idx_reg <= out_idx_next;
        end
    end

    // Quarter volume, formed once per element.
    tpgc_volume u_volume (
        .aclk          (aclk),
        .en            (ctrl.mag_en),
        .det_jacobian  (detj_reg),
        .volume_factor (vf_reg),
        .v4            (v4)
    );

    // One lane per dimension.
    tpgc_lane u_lane_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .grad     (s_data.grad_x),
        .pressure (s_data.pressure),
        .v4       (v4),
        .contrib  (cx)
    );

    tpgc_lane u_lane_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .grad     (s_data.grad_y),
        .pressure (s_data.pressure),
        .v4       (v4),
        .contrib  (cy)
    );

    tpgc_lane u_lane_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .grad     (s_data.grad_z),
        .pressure (s_data.pressure),
        .v4       (v4),
        .contrib  (cz)
    );

    // Merge the lane results with the node number, or build the error item.
    always_comb begin
        if (state_reg == ST_ERR) begin
            m_data.out_node  = '0;
            m_data.contrib_x = '0;
            m_data.contrib_y = '0;
            m_data.contrib_z = '0;
            m_data.status    = STATUS_BAD_VOL;
            m_data.last      = 1'b1;
        end else begin
            m_data.out_node  = nodes_reg[out_idx_reg];
            m_data.contrib_x = cx;
            m_data.contrib_y = cy;
            m_data.contrib_z = cz;
            m_data.status    = STATUS_OK;
            m_data.last      = (out_idx_reg == LAST_NODE);
        end
    end

endmodule

/* src/tpgc_lane.sv */
// One dimension lane: gradient product, running sum and saturated correction.
// Depends on tpgc_pkg for widths and the lane control struct.
module tpgc_lane (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tpgc_pkg::lane_ctrl_t               ctrl,
    input  logic signed [tpgc_pkg::DATA_W-1:0] grad,
    input  logic signed [tpgc_pkg::DATA_W-1:0] pressure,
    input  logic [tpgc_pkg::V4_W-1:0]          v4,
    output logic signed [tpgc_pkg::DATA_W-1:0] contrib
);
    import tpgc_pkg::*;

    logic signed [SUM_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic                     big_reg;
    logic [46:0]              hi_p_reg;
    logic [62:0]              lo_p_reg;
    logic [SUM_W-1:0]         cprod;
    logic [DATA_W-1:0]        limit;
    logic [DATA_W-1:0]        magsel;
    logic [DATA_W-1:0]        contrib_reg;

    // Product of this node's gradient and pressure, taken when the node is accepted.
    always_ff @(posedge aclk) begin
        if (ctrl.prod_en) begin
            prod_reg <= grad * pressure;
        end
    end

    // The arithmetic shift floors the Q32.32 product to Q48.16.
    always_comb begin
        sum_next = sum_reg + (prod_reg >>> FRAC_W);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            sum_reg <= '0;
        end else if (ctrl.acc_en) begin
            sum_reg <= sum_next;
        end
    end

    // Sign and magnitude of the finished gradient.
    always_ff @(posedge aclk) begin
        if (ctrl.mag_en) begin
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= sum_reg[SUM_W-1] ? (SUM_W'(0) - $unsigned(sum_reg)) : $unsigned(sum_reg);
        end
    end

    // Two partial products of the magnitude with the quarter volume.
    always_ff @(posedge aclk) begin
        if (ctrl.cmul_en) begin
            big_reg  <= |mag_reg[SUM_W-1:48];
            hi_p_reg <= mag_reg[47:32] * v4;
            lo_p_reg <= mag_reg[31:0] * v4;
        end
    end

    // Join the partial products, truncate toward zero and saturate the negated value.
    always_comb begin
        cprod  = big_reg ? (SUM_W'(1) << 40)
                         : ({1'b0, hi_p_reg, 16'b0} + {17'b0, lo_p_reg[62:16]});
        limit  = neg_reg ? 32'h7FFF_FFFF : 32'h8000_0000;
        magsel = (cprod > {32'b0, limit}) ? limit : cprod[DATA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.csum_en) begin
            contrib_reg <= neg_reg ? magsel : (DATA_W'(0) - magsel);
        end
    end

    assign contrib = $signed(contrib_reg);

endmodule

/* src/tpgc_volume.sv */
// Quarter element volume from the Jacobian determinant and the volume factor.
// Depends on tpgc_pkg for widths.
module tpgc_volume (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [tpgc_pkg::DATA_W-1:0] det_jacobian,
    input  logic [tpgc_pkg::VF_W-1:0]          volume_factor,
    output logic [tpgc_pkg::V4_W-1:0]          v4
);
    import tpgc_pkg::*;

    logic [V4_W+VF_W-1:0] vprod;
    logic                 positive;
    logic [V4_W-1:0]      v4_reg;

    // A non-positive determinant gives a zero volume, which the sequencer reports.
    always_comb begin
        positive = !det_jacobian[DATA_W-1] && (det_jacobian != '0);
        vprod    = det_jacobian[V4_W-1:0] * volume_factor;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v4_reg <= positive ? vprod[V4_W+VF_W-1:FRAC_W] : '0;
        end
    end

    assign v4 = v4_reg;

endmodule

/* src/tpgc_checker.sv */
// Port-level checks of the pressure gradient unit, bound to its top level.
// Depends on tpgc_pkg and the assertion macros header.
`include "tet_pressure_gradient_correction_unit_defines.svh"

module tpgc_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input tpgc_pkg::out_item_t       m_data
);
    import tpgc_pkg::*;

    // A result that waits keeps its payload.
    `TPGC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // An error item is the lone, zeroed result of its element.
    `TPGC_ASSERT_SAME(a_err_item, aclk, aresetn, m_valid && m_data.status == STATUS_BAD_VOL, m_data.last && m_data.out_node == '0 && m_data.contrib_x == '0 && m_data.contrib_y == '0 && m_data.contrib_z == '0)

    // No node is taken while results of an element are pending.
    `TPGC_ASSERT_SAME(a_no_overlap, aclk, aresetn, m_valid, !s_ready)

    // Taking the final result returns the block to idle.
    `TPGC_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && m_data.last, !m_valid && s_ready)

endmodule

bind tet_pressure_gradient_correction_unit tpgc_checker u_tpgc_checker (.*);

/* dv/tpgc_correction_monitor.sv */
`timescale 1ns / 100ps
// Monitor for the tetrahedron pressure gradient correction unit: watches the
// configuration, node and result channels, predicts results and compares them.
// Depends on tpgc_pkg for the item types and the block's constants.
module tpgc_correction_monitor (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [tpgc_pkg::VF_W-1:0] cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  tpgc_pkg::in_item_t        s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  tpgc_pkg::out_item_t       m_data,
    input  logic                      drain_check,
    output int                        outstanding,
    output int                        mismatch_count
);
    import tpgc_pkg::*;

    // Shadow of the block's register and element state.
    logic [VF_W-1:0]   vol_factor;
    longint            grad_sum [3];
    logic [NODE_W-1:0] element_nodes [NODES_PER_ELEMENT];
    logic [1:0]        node_slot;
    out_item_t         expected_corrections [$];
    out_item_t         want;
    bit                drain_reported;

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
        drain_reported = 1'b0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Scales one gradient sum by the quarter volume, negates it and saturates.
    // The magnitude is truncated, so the rounding goes toward zero.
    function automatic logic [DATA_W-1:0] correction(input longint sum,
                                                     input logic [63:0] quarter_vol);
        logic [63:0] mag;
        logic [95:0] scaled;
        mag    = (sum < 0) ? 64'(-sum) : 64'(sum);
        scaled = (96'(mag) * 96'(quarter_vol)) >> FRAC_W;
        if (sum < 0)
            return (scaled > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : scaled[31:0];
        return (scaled > 96'h8000_0000) ? 32'h8000_0000 : 32'd0 - scaled[31:0];
    endfunction

    // Folds one node into the element and queues the results that it completes.
    task automatic fold_node(input in_item_t node);
        logic [63:0] quarter_vol;
        out_item_t   item;
        quarter_vol = '0;
        element_nodes[node_slot] = node.node_index;
        // Each nodal product is floored back to Q48.16 before it is summed.
        grad_sum[0] += (longint'(node.grad_x) * longint'(node.pressure)) >>> FRAC_W;
        grad_sum[1] += (longint'(node.grad_y) * longint'(node.pressure)) >>> FRAC_W;
        grad_sum[2] += (longint'(node.grad_z) * longint'(node.pressure)) >>> FRAC_W;
        if (node_slot != LAST_NODE) begin
            node_slot++;
        end else begin
            // A solid element is dropped without any result.
            if (!node.solid_material) begin
                if (node.det_jacobian > 0)
                    quarter_vol = (64'($unsigned(node.det_jacobian)) * 64'(vol_factor))
                                  >> FRAC_W;
                if (quarter_vol == 0) begin
                    item        = '0;
                    item.status = STATUS_BAD_VOL;
                    item.last   = 1'b1;
                    expected_corrections.push_back(item);
                end else begin
                    for (int a = 0; a < NODES_PER_ELEMENT; a++) begin
                        item.out_node  = element_nodes[a];
                        item.contrib_x = correction(grad_sum[0], quarter_vol);
                        item.contrib_y = correction(grad_sum[1], quarter_vol);
                        item.contrib_z = correction(grad_sum[2], quarter_vol);
                        item.status    = STATUS_OK;
                        item.last      = (a == NODES_PER_ELEMENT - 1);
                        expected_corrections.push_back(item);
                    end
                end
            end
            grad_sum  = '{0, 0, 0};
            node_slot = '0;
        end
    endtask

    // Channel sampling; results are checked before the same edge's node is folded.
    always @(posedge aclk) begin
        if (!aresetn) begin
            vol_factor = VOLUME_FACTOR_RESET;
            grad_sum   = '{0, 0, 0};
            node_slot  = '0;
            for (int a = 0; a < NODES_PER_ELEMENT; a++)
                element_nodes[a] = '0;
            expected_corrections.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_corrections.size() == 0) begin
                    report_mismatch($sformatf("result item with nothing expected: %h",
                                              m_data));
                end else begin
                    want = expected_corrections.pop_front();
                    if (m_data.out_node !== want.out_node)
                        report_mismatch($sformatf("out_node got %0d, expected %0d",
                                                  m_data.out_node, want.out_node));
                    if (m_data.contrib_x !== want.contrib_x)
                        report_mismatch($sformatf("contrib_x got %h, expected %h",
                                                  m_data.contrib_x, want.contrib_x));
                    if (m_data.contrib_y !== want.contrib_y)
                        report_mismatch($sformatf("contrib_y got %h, expected %h",
                                                  m_data.contrib_y, want.contrib_y));
                    if (m_data.contrib_z !== want.contrib_z)
                        report_mismatch($sformatf("contrib_z got %h, expected %h",
                                                  m_data.contrib_z, want.contrib_z));
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status got %b, expected %b",
                                                  m_data.status, want.status));
                    if (m_data.last !== want.last)
                        report_mismatch($sformatf("last got %b, expected %b",
                                                  m_data.last, want.last));
                end
            end
            if (cfg_valid && cfg_ready)
                vol_factor = cfg_data;
            if (s_valid && s_ready)
                fold_node(s_data);
            // At the end of the run every expected result must have come.
            if (drain_check && !drain_reported) begin
                drain_reported = 1'b1;
                if (expected_corrections.size() != 0)
                    report_mismatch($sformatf("%0d result items never arrived",
                                              expected_corrections.size()));
            end
        end
        outstanding <= expected_corrections.size();
    end

endmodule

/* dv/tb_tet_pressure_gradient_correction_unit.sv */
`timescale 1ns / 100ps
// Top of the pressure gradient correction testbench: clock, reset, node and
// register stimulus, receiver stalls and the verdict. Depends on tpgc_pkg,
// the unit under test and tpgc_correction_monitor.
module tb_tet_pressure_gradient_correction_unit;
    import tpgc_pkg::*;

    typedef enum int {
        ELEM_FLUID,
        ELEM_SOLID,
        ELEM_NONPOS,
        ELEM_TINY
    } element_kind_t;

    localparam int          HOLD_OFF_CYCLES = 80;
    localparam int          SETTLE_CYCLES   = 12;
    localparam logic [31:0] Q_ONE           = 32'h0001_0000;
    localparam logic [31:0] Q_MIN           = 32'h8000_0000;
    localparam logic [31:0] Q_MAX           = 32'h7FFF_FFFF;

    logic            aclk;
    logic            aresetn     = 1'b0;
    logic            cfg_valid   = 1'b0;
    logic            cfg_ready;
    logic [VF_W-1:0] cfg_data    = '0;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    in_item_t        s_data      = '0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    out_item_t       m_data;
    logic            drain_check = 1'b0;
    logic            hold_off_req = 1'b0;
    int              outstanding;
    int              mismatch_count;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    logic [VF_W-1:0] cur_volume_factor = VOLUME_FACTOR_RESET;

    tet_pressure_gradient_correction_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    tpgc_correction_monitor u_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .drain_check    (drain_check),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one node item, after a random gap, and waits until it is taken.
    task automatic offer_node(input logic [15:0] idx, input logic [31:0] p,
                              input logic [31:0] gx, input logic [31:0] gy,
                              input logic [31:0] gz, input logic [31:0] det,
                              input logic solid);
        in_item_t node;
        node.node_index     = idx;
        node.pressure       = p;
        node.grad_x         = gx;
        node.grad_y         = gy;
        node.grad_z         = gz;
        node.det_jacobian   = det;
        node.solid_material = solid;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= node;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Lets the block drain all results and finish any dropped element.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the volume factor once the block is idle.
    task automatic write_volume_factor(input logic [VF_W-1:0] value);
        wait_drained();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_volume_factor = value;
    endtask

    // Moderate Q16.16 values mostly; wide ones reach saturation and extremes.
    function automatic logic [31:0] pick_value(input bit wide);
        if (wide) begin
            case ($urandom_range(5))
                0:       return Q_MIN;
                1:       return Q_MAX;
                default: return $urandom;
            endcase
        end
        return 32'($urandom_range(1 << 21)) - 32'(1 << 20);
    endfunction

    // An element of moderate random nodes with a chosen volume and material.
    task automatic send_shaped_element(input logic [31:0] det, input logic solid);
        for (int a = 0; a < NODES_PER_ELEMENT; a++)
            offer_node(16'($urandom_range(65535)), pick_value(0), pick_value(0),
                       pick_value(0), pick_value(0),
                       (a == NODES_PER_ELEMENT - 1) ? det : $urandom,
                       (a == NODES_PER_ELEMENT - 1) ? solid : 1'($urandom_range(1)));
    endtask

    // A random element: mostly fluid, some solid, some with a bad volume.
    task automatic send_random_element();
        element_kind_t kind;
        bit            wide;
        int            roll;
        int            tiny_max;
        logic [31:0]   det;
        roll     = $urandom_range(99);
        kind     = (roll < 65) ? ELEM_FLUID : (roll < 77) ? ELEM_SOLID :
                   (roll < 89) ? ELEM_NONPOS : ELEM_TINY;
        wide     = ($urandom_range(3) == 0);
        tiny_max = (cur_volume_factor == 0) ? 1000 : 65535 / cur_volume_factor;
        case (kind)
            ELEM_FLUID:  det = wide ? 32'($urandom_range(Q_MAX, 1))
                                    : 32'($urandom_range(1 << 22, 1 << 14));
            ELEM_NONPOS: det = ($urandom_range(3) == 0) ? 32'd0 : {1'b1, 31'($urandom)};
            ELEM_TINY:   det = 32'($urandom_range(tiny_max, 1));
            default:     det = $urandom;
        endcase
        for (int a = 0; a < NODES_PER_ELEMENT; a++) begin
            if (a < NODES_PER_ELEMENT - 1)
                offer_node(16'($urandom_range(65535)), pick_value(wide), pick_value(wide),
                           pick_value(wide), pick_value(wide), $urandom,
                           1'($urandom_range(1)));
            else
                offer_node(16'($urandom_range(65535)), pick_value(wide), pick_value(wide),
                           pick_value(wide), pick_value(wide), det,
                           kind == ELEM_SOLID);
        end
    endtask

    // Stimulus sequence and verdict.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 80;
        write_volume_factor(VOLUME_FACTOR_RESET);

        // Fluid element with extreme node numbers; the solid flag on an early
        // node must be ignored.
        offer_node(16'd0,     32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                   32'hFFFF_0000, 32'h0000_1234, 1'b0);
        offer_node(16'hFFFF,  32'h0002_0000, Q_ONE, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
        offer_node(16'd1,     32'hFFFE_8000, 32'd0, Q_ONE, 32'd0, 32'd0, 1'b0);
        offer_node(16'd2,     32'h0000_8000, 32'd0, 32'd0, Q_ONE, 32'h0006_0000, 1'b0);
        // Extreme products: sums saturate both ways, one dimension stays zero.
        for (int a = 0; a < NODES_PER_ELEMENT; a++)
            offer_node(16'(100 + a), Q_MIN, Q_MIN, Q_MAX, 32'd0, Q_MAX, 1'b0);
        // Solid element, then zero, most negative and too small volumes.
        send_shaped_element(32'h0002_0000, 1'b1);
        send_shaped_element(32'd0, 1'b0);
        send_shaped_element(Q_MIN, 1'b0);
        send_shaped_element(32'd1, 1'b0);

        // Random phases across register settings and idling patterns.
        write_volume_factor(16'hFFFF);
        repeat (7) send_random_element();

        send_idle_pct = 80;
        recv_idle_pct = 36;
        write_volume_factor(16'd1);
        repeat (7) send_random_element();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_volume_factor(16'($urandom_range(65535, 2)));
        hold_off_req <= 1'b1;
        repeat (6) send_random_element();

        // A zero factor turns every fluid element into an error item.
        write_volume_factor(16'd0);
        repeat (2) send_random_element();

        wait_drained();
        drain_check <= 1'b1;
        repeat (3) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
